[hdl/tlik_pkg.sv]
// ----------------------------------------------------------------------------
// tlik_pkg
// shared types, constants and functions of the two-link arm ik block
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW       = 5;
  localparam int LenW        = 14;
  localparam int PosW        = 16;

  localparam logic [1:0] CFG_UPPER    = 2'd0;
  localparam logic [1:0] CFG_FOREARM  = 2'd1;
  localparam logic [1:0] CFG_OFFSET   = 2'd2;

  localparam logic signed [31:0] HalfPiQ24 = 32'sd26353589;

  // job handed from front to back
  typedef struct packed {
    logic signed [PosW-1:0] tx;
    logic signed [PosW-1:0] ty;
    logic signed [PosW-1:0] th;
    logic [LenW-1:0]        l1;
    logic [LenW-1:0]        l2;
    logic [LenW-1:0]        off;
  } tlik_job_t;

  typedef struct packed {
    logic signed [16:0] pitch;
    logic [14:0]        elbow;
    logic               ok;
  } tlik_res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ1, S_SQ1W, S_D, S_R2, S_SQ2, S_SQ2W, S_DEN, S_DIVP, S_DIVPW,
    S_DIVE, S_DIVEW, S_CHK, S_SQS, S_SQSW, S_ATP, S_ATPW, S_SQE, S_SQEW,
    S_ATE, S_ATEW, S_ATH, S_ATHW, S_DONE
  } tlik_state_t;

  function automatic logic signed [31:0] atan_q24(input logic [StepW-1:0] i);
    logic signed [31:0] v;
    v = 32'sd0;
    case (i)
      5'd0:  v = 32'sd13176795;
      5'd1:  v = 32'sd7778716;
      5'd2:  v = 32'sd4110060;
      5'd3:  v = 32'sd2086331;
      5'd4:  v = 32'sd1047214;
      5'd5:  v = 32'sd524117;
      5'd6:  v = 32'sd262123;
      5'd7:  v = 32'sd131069;
      default: v = (i < 5'd24) ? (32'sd65536 >>> (i - 5'd8)) : 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/two_link_arm_inverse_kinematics_top.sv]
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_top
// inverse kinematics for a two-link planar arm
// ----------------------------------------------------------------------------
// One result word per target word. Four square roots (21 steps each), two
// 48-step divisions and three 16-step cordic passes run one after another on
// shared units in the back-end sequencer, with a set-up state ahead of each;
// the result is then registered and held through any output stall. A target
// inside the shoulder offset or with a zero link length finishes after the
// first square root, one whose cosine falls out of range after the two
// divisions. A two-entry queue lets new targets in while one is computed and
// its result waits.
module two_link_arm_inverse_kinematics_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_x, target_y, target_height
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pitch_angle, elbow_angle, reachable, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);
  import tlik_pkg::*;

  logic      job_valid, job_ready;
  tlik_job_t job;
  tlik_res_t res;

  tlik_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .job_valid, .job, .job_ready);

  tlik_back u_back (.clk, .rst_n, .job_valid, .job, .job_ready,
    .res_valid(out_tvalid), .res, .res_ready(out_tready));

  assign out_tdata = {7'd0, res.ok, res.elbow, res.pitch};
endmodule

[hdl/tlik_isqrt.sv]
// ----------------------------------------------------------------------------
// tlik_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tlik_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [41:0] radicand,
  output logic        done,
  output logic [20:0] root
);
  import tlik_pkg::*;

  logic [41:0] rem_r, rem_nxt;
  logic [41:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [41:0] trial;
  logic [41:0] bit_v;

  always_comb begin
    bit_v   = 42'd1 << {cnt_r, 1'b0};
    trial   = res_r + bit_v;
    rem_nxt = rem_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done    = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      cnt_nxt  = 5'd20;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shifting-bit method, res holds the partial root scaled by the bit
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_v;
      end else begin
        res_nxt = res_r >> 1;
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  assign root = res_nxt[20:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end
endmodule

[hdl/tlik_div.sv]
// ----------------------------------------------------------------------------
// tlik_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tlik_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [34:0] den,
  output logic        done,
  output logic [47:0] quo
);
  import tlik_pkg::*;

  logic [47:0] q_r, q_nxt;
  logic [35:0] rm_r, rm_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [35:0] sh;

  always_comb begin
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    sh       = {rm_r[34:0], q_r[47]};
    if (start) begin
      q_nxt    = num;
      rm_nxt   = '0;
      cnt_nxt  = 6'd47;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den}) begin
        rm_nxt = sh - {1'b0, den};
        q_nxt  = {q_r[46:0], 1'b1};
      end else begin
        rm_nxt = sh;
        q_nxt  = {q_r[46:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  assign quo = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
  end
endmodule

[hdl/tlik_cordic.sv]
// ----------------------------------------------------------------------------
// tlik_cordic
// vectoring cordic atan2, one rotation per cycle, result in rad*8192
// ----------------------------------------------------------------------------
module tlik_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [21:0] y_in,
  input  logic signed [21:0] x_in,
  output logic               done,
  output logic signed [17:0] angle
);
  import tlik_pkg::*;

  logic signed [37:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [StepW-1:0]   i_r, i_nxt;
  logic               busy_r, busy_nxt;
  logic signed [37:0] xs, ys, xi, yi;
  logic signed [31:0] zr;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done = 1'b0;
    xi = 38'(x_in) <<< 14;
    yi = 38'(y_in) <<< 14;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      x_nxt = xi; y_nxt = yi; z_nxt = '0;
      if (xi < 0) begin
        if (yi >= 0) begin
          x_nxt = yi; y_nxt = -xi; z_nxt = HalfPiQ24;
        end else begin
          x_nxt = -yi; y_nxt = xi; z_nxt = -HalfPiQ24;
        end
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_q24(i_r);
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_q24(i_r);
      end
      if (i_r == StepW'(CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        i_nxt = i_r + StepW'(1);
      end
    end
    // round the angle including the rotation finishing this cycle
    zr = z_nxt + 32'sd1024;
  end

  assign angle = 18'(zr >>> 11);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end
endmodule

[hdl/tlik_back.sv]
// ----------------------------------------------------------------------------
// tlik_back
// sequencer that runs one job through the shared sqrt, divider and cordic
// ----------------------------------------------------------------------------
module tlik_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  tlik_pkg::tlik_job_t job,
  output logic                job_ready,
  output logic                res_valid,
  output tlik_pkg::tlik_res_t res,
  input  logic                res_ready
);
  import tlik_pkg::*;

  tlik_state_t st_r, st_nxt;
  tlik_job_t   j_r;
  logic signed [17:0] d_r;
  logic [33:0] r2_r;
  logic [20:0] rq_r;
  logic [34:0] denp_r, dene_r;
  logic signed [35:0] nump_r, nume_r;
  logic signed [17:0] cp_r, ce_r;
  logic signed [17:0] ap_r, ah_r, ae_r;
  logic [20:0] sroot_r;
  logic        ok_r;
  tlik_res_t   out_r;
  logic        outv_r;

  logic        sq_start, sq_done, dv_start, dv_done, co_start, co_done;
  logic [41:0] sq_in;
  logic [20:0] sq_out;
  logic [47:0] dv_num, dv_quo;
  logic [34:0] dv_den;
  logic signed [21:0] co_y, co_x;
  logic signed [17:0] co_ang;

  tlik_isqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_in),
                     .done(sq_done), .root(sq_out));
  tlik_div u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                  .done(dv_done), .quo(dv_quo));
  tlik_cordic u_cor (.clk, .rst_n, .start(co_start), .y_in(co_y), .x_in(co_x),
                     .done(co_done), .angle(co_ang));

  logic signed [31:0] sx, sy, sh;
  logic signed [35:0] dd;
  logic signed [31:0] cc;
  logic [35:0] nmag;
  logic [35:0] pmag;
  logic signed [17:0] qs;
  logic signed [17:0] qp;

  always_comb begin
    st_nxt = st_r;
    sq_start = 1'b0; dv_start = 1'b0; co_start = 1'b0;
    sq_in = '0; dv_num = '0; dv_den = dene_r; co_y = '0; co_x = '0;
    job_ready = (st_r == S_IDLE);
    sx = 32'(j_r.tx) * 32'(j_r.tx);
    sy = 32'(j_r.ty) * 32'(j_r.ty);
    sh = 32'(j_r.th) * 32'(j_r.th);
    dd = 36'(d_r) * 36'(d_r);
    cc = 32'(cp_r) * 32'(cp_r);
    nmag = '0;
    pmag = nump_r[35] ? 36'(-nump_r) : 36'(nump_r);
    // saturate large quotients so the range check still trips
    qs = (dv_quo[47:16] != '0) ? 18'sd65535 : 18'(dv_quo[16:0]);
    // a pitch numerator of 2^31 or more always gives a cosine beyond one
    qp = (pmag[35:31] != '0) ? 18'sd65535 : qs;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_SQ1;
      S_SQ1: begin
        sq_start = 1'b1;
        sq_in = 42'(sx) + 42'(sy);
        st_nxt = S_SQ1W;
      end
      S_SQ1W: if (sq_done) st_nxt = S_D;
      S_D: st_nxt = S_R2;
      S_R2: begin
        if (d_r <= 0 || j_r.l1 == '0 || j_r.l2 == '0) st_nxt = S_DONE;
        else st_nxt = S_SQ2;
      end
      S_SQ2: begin
        sq_start = 1'b1;
        sq_in = {r2_r, 8'd0};
        st_nxt = S_SQ2W;
      end
      S_SQ2W: if (sq_done) st_nxt = S_DEN;
      S_DEN: st_nxt = S_DIVP;
      S_DIVP: begin
        dv_start = 1'b1;
        dv_num = {pmag[30:0], 17'd0};
        dv_den = denp_r;
        st_nxt = S_DIVPW;
      end
      S_DIVPW: begin
        dv_den = denp_r;
        if (dv_done) st_nxt = S_DIVE;
      end
      S_DIVE: begin
        nmag = nume_r[35] ? 36'(-nume_r) : 36'(nume_r);
        dv_start = 1'b1;
        dv_num = {nmag[33:0], 14'd0};
        st_nxt = S_DIVEW;
      end
      S_DIVEW: if (dv_done) st_nxt = S_CHK;
      S_CHK: begin
        if (cp_r > 18'sd16384 || cp_r < -18'sd16384 ||
            ce_r > 18'sd16384 || ce_r < -18'sd16384) st_nxt = S_DONE;
        else st_nxt = S_SQS;
      end
      S_SQS: begin
        sq_start = 1'b1;
        sq_in = 42'(32'sd268435456 - cc);
        st_nxt = S_SQSW;
      end
      S_SQSW: if (sq_done) st_nxt = S_ATP;
      S_ATP: begin
        co_start = 1'b1;
        co_y = 22'(sroot_r); co_x = 22'(cp_r);
        st_nxt = S_ATPW;
      end
      S_ATPW: if (co_done) st_nxt = S_SQE;
      S_SQE: begin
        sq_start = 1'b1;
        sq_in = 42'(32'sd268435456 - 32'(ce_r) * 32'(ce_r));
        st_nxt = S_SQEW;
      end
      S_SQEW: if (sq_done) st_nxt = S_ATE;
      S_ATE: begin
        co_start = 1'b1;
        co_y = 22'(sroot_r); co_x = 22'(ce_r);
        st_nxt = S_ATEW;
      end
      S_ATEW: if (co_done) st_nxt = S_ATH;
      S_ATH: begin
        co_start = 1'b1;
        co_y = 22'(j_r.th); co_x = 22'(d_r);
        st_nxt = S_ATHW;
      end
      S_ATHW: if (co_done) st_nxt = S_DONE;
      S_DONE: if (!outv_r || res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && (!outv_r || res_ready)) outv_r <= 1'b1;
      else if (res_ready) outv_r <= 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        j_r  <= job;
        ok_r <= 1'b0;
      end
      S_SQ1W: if (sq_done) d_r <= 18'(sq_out) - 18'(j_r.off);
      S_D:  r2_r <= 34'(sh) + 34'(dd);
      S_SQ2W: if (sq_done) rq_r <= sq_out;
      S_DEN: begin
        denp_r <= 35'(rq_r) * 35'(j_r.l1);
        dene_r <= 35'(j_r.l1) * 35'(j_r.l2) * 35'd2;
        nump_r <= 36'(r2_r) + 36'(j_r.l1) * 36'(j_r.l1) - 36'(j_r.l2) * 36'(j_r.l2);
        nume_r <= 36'(j_r.l1) * 36'(j_r.l1) + 36'(j_r.l2) * 36'(j_r.l2) - 36'(r2_r);
      end
      S_DIVPW: if (dv_done) cp_r <= nump_r[35] ? -qp : qp;
      S_DIVEW: if (dv_done) ce_r <= nume_r[35] ? -qs : qs;
      S_SQSW: if (sq_done) sroot_r <= sq_out;
      S_ATPW: if (co_done) ap_r <= co_ang;
      S_SQEW: if (sq_done) sroot_r <= sq_out;
      S_ATEW: if (co_done) ae_r <= co_ang;
      S_ATHW: if (co_done) begin
        ah_r <= co_ang;
        ok_r <= 1'b1;
      end
      S_DONE: if (!outv_r || res_ready) begin
        out_r.ok    <= ok_r;
        out_r.pitch <= ok_r ? 17'(ap_r + ah_r) : '0;
        out_r.elbow <= ok_r ? 15'(ae_r) : '0;
      end
      default: ;
    endcase
  end

  assign res_valid = outv_r;
  assign res       = out_r;
endmodule

[hdl/tlik_front.sv]
// ----------------------------------------------------------------------------
// tlik_front
// takes targets, snapshots the link registers and queues jobs
// ----------------------------------------------------------------------------
module tlik_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  output logic                job_valid,
  output tlik_pkg::tlik_job_t job,
  input  logic                job_ready
);
  import tlik_pkg::*;

  logic [LenW-1:0] l1_r, l2_r, off_r;
  tlik_job_t q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= '0; l2_r <= '0; off_r <= '0;
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_UPPER:   l1_r  <= cfg_data;
          CFG_FOREARM: l2_r  <= cfg_data;
          CFG_OFFSET:  off_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) wp_r <= ~wp_r;
      if (job_valid && job_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_tvalid && in_tready)) - 2'((job_valid && job_ready));
    end
    if (in_tvalid && in_tready)
      q_r[wp_r] <= '{tx: in_tdata[15:0], ty: in_tdata[31:16], th: in_tdata[47:32],
                     l1: l1_r, l2: l2_r, off: off_r};
  end
endmodule

[test/two_link_arm_inverse_kinematics_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_top_tb
// self-checking bench for the two-link arm inverse kinematics block
// ----------------------------------------------------------------------------
// Target words go in through a bursty driver. Each accepted word is run
// through a bit-exact integer model of the kinematics: reach, law of cosines,
// cordic acos and atan2. The predicted word is queued and compared field by
// field with what the block returns. Link lengths are reprogrammed between
// phases, only once the block has drained.
module two_link_arm_inverse_kinematics_top_tb;
  import tlik_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int IdleLimit = 20000;
  localparam int DrainWait = 400;
  localparam int HoldCycles = 900;

  typedef struct packed {
    logic signed [16:0] pitch;
    logic [14:0]        elbow;
    logic               reach_ok;
  } ik_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;  // target_x, target_y, target_height
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;      // pitch_angle, elbow_angle, reachable, zero fill
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  logic [47:0] target_q[$];
  ik_word_t    angles_q[$];
  logic [13:0] arm_upper, arm_fore, arm_offset;
  int errors = 0;
  int n_targets = 0, n_results = 0, n_reached = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  localparam longint AtanTab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  two_link_arm_inverse_kinematics_top uut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, result rounded to rad*8192
  function automatic longint angle_of(longint y, longint x);
    longint z, xs, ys, t;
    z = 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 26353589;
      end else begin
        x = -y; y = t; z = -26353589;
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + AtanTab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - AtanTab[i];
      end
    end
    return (z + 1024) >>> 11;
  endfunction

  function automatic longint arc_cos(longint c);
    return angle_of(longint'(int_sqrt(268435456 - c * c)), c);
  endfunction

  function automatic longint scaled_quot(longint num, longint unsigned scale,
                                         longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag * scale) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic ik_word_t solve_target(logic [47:0] w);
    longint x, y, h, l1, l2, d, r2, cp, ce, pitch, elbow;
    longint unsigned rq4, denp, dene;
    bit ok;
    ik_word_t r;
    x = longint'($signed(w[15:0]));
    y = longint'($signed(w[31:16]));
    h = longint'($signed(w[47:32]));
    l1 = arm_upper;
    l2 = arm_fore;
    d = longint'(int_sqrt(x * x + y * y)) - longint'(arm_offset);
    pitch = 0;
    elbow = 0;
    ok = (d > 0) && l1 != 0 && l2 != 0;
    if (ok) begin
      r2 = h * h + d * d;
      rq4 = int_sqrt(r2 << 8);
      denp = rq4 * l1;
      dene = 2 * l1 * l2;
      if (denp == 0) begin
        ok = 0;
      end else begin
        cp = scaled_quot(r2 + l1 * l1 - l2 * l2, 131072, denp);
        ce = scaled_quot(l1 * l1 + l2 * l2 - r2, 16384, dene);
        if (cp > 16384 || cp < -16384 || ce > 16384 || ce < -16384) begin
          ok = 0;
        end else begin
          pitch = arc_cos(cp) + angle_of(h, d);
          elbow = arc_cos(ce);
        end
      end
    end
    if (!ok) begin
      pitch = 0;
      elbow = 0;
    end
    r.pitch = pitch[16:0];
    r.elbow = elbow[14:0];
    r.reach_ok = ok;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
    errors++;
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        angles_q.push_back(solve_target(in_tdata));
        n_targets++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (target_q.size() > 0) begin
          in_tdata <= target_q.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req && hold_left == 0) hold_left = HoldCycles;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0, 1: out_tready <= 1'b1;
          2: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ik_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pitch    = out_tdata[16:0];
      got.elbow    = out_tdata[31:17];
      got.reach_ok = out_tdata[32];
      if (angles_q.size() == 0) begin
        $display("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        want = angles_q.pop_front();
        if (got.pitch !== want.pitch) report("pitch_angle", got.pitch, want.pitch);
        if (got.elbow !== want.elbow) report("elbow_angle", got.elbow, want.elbow);
        if (got.reach_ok !== want.reach_ok)
          report("reachable", got.reach_ok, want.reach_ok);
        if (out_tdata[39:33] !== '0) report("zero fill", out_tdata[39:33], 0);
        if (want.reach_ok) n_reached++;
      end
      n_results++;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_UPPER:   arm_upper = val;
      CFG_FOREARM: arm_fore = val;
      CFG_OFFSET:  arm_offset = val;
      default: ;
    endcase
  endtask

  // checked on the falling edge so the driver's updates have settled
  task automatic drain();
    while (target_q.size() > 0 || in_tvalid || angles_q.size() > 0) @(negedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic logic [47:0] pack_target(longint x, longint y, longint h);
    logic [15:0] a, b, c;
    a = (x > 32767) ? 16'sd32767 : (x < -32768) ? -16'sd32768 : x[15:0];
    b = (y > 32767) ? 16'sd32767 : (y < -32768) ? -16'sd32768 : y[15:0];
    c = (h > 32767) ? 16'sd32767 : (h < -32768) ? -16'sd32768 : h[15:0];
    return {c, b, a};
  endfunction

  // mostly targets near the working envelope, some raw noise
  task automatic queue_random(int n);
    longint span, rr, x, y, h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        target_q.push_back(48'({$urandom, $urandom}));
      end else begin
        span = longint'(arm_upper) + arm_fore;
        rr = $urandom_range(0, span * 11 / 10 + 2);
        h = longint'($urandom_range(0, 2 * rr)) - rr;
        rr = longint'(arm_offset) + longint'(int_sqrt(rr * rr - ((h * h) % (rr * rr + 1))));
        x = longint'($urandom_range(0, 2 * rr)) - rr;
        y = longint'(int_sqrt(rr * rr - x * x));
        if ($urandom_range(0, 1)) y = -y;
        target_q.push_back(pack_target(x, y, h));
      end
    end
  endtask

  initial begin
    logic [13:0] cfgs[5][3];
    cfgs = '{
      '{14'd3000, 14'd2500, 14'd500},
      '{14'd16383, 14'd16383, 14'd16383},
      '{14'd1, 14'd1, 14'd0},
      '{14'd10000, 14'd4000, 14'd0},
      '{14'd2000, 14'd7000, 14'd10000}};
    arm_upper = '0;
    arm_fore = '0;
    arm_offset = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // zero link lengths straight after reset
    queue_random(20);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_UPPER, cfgs[p][0]);
      write_reg(CFG_FOREARM, cfgs[p][1]);
      write_reg(CFG_OFFSET, cfgs[p][2]);
      if (p == 2) write_reg(CFG_UNUSED, 14'h3FFF);
      if (p == 0) begin
        target_q.push_back(pack_target(0, 0, 0));
        target_q.push_back(pack_target(300, 400, 0));
        target_q.push_back(pack_target(500, 0, 0));
        target_q.push_back(pack_target(501, 0, 0));
        target_q.push_back(pack_target(6500, 0, 0));
        target_q.push_back(pack_target(6501, 0, 0));
        target_q.push_back(pack_target(0, 6000, -1000));
        target_q.push_back(pack_target(-3000, -2000, 1500));
        target_q.push_back(pack_target(1200, 0, 0));
        target_q.push_back(pack_target(700, 0, 300));
        target_q.push_back(pack_target(2000, 2000, -3000));
        target_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
        target_q.push_back({16'h8000, 16'h8000, 16'h8000});
        target_q.push_back({16'h0000, 16'h8000, 16'h7FFF});
        target_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
        target_q.push_back(pack_target(4000, 0, 3000));
        target_q.push_back(pack_target(4000, 0, -3000));
        target_q.push_back(pack_target(-20000, 20000, 20000));
        target_q.push_back(pack_target(1000, 0, 0));
        target_q.push_back(pack_target(3000, 3000, 0));
        drain();
      end
      if (p == 1) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      queue_random(p == 2 ? 150 : 345);
      drain();
    end
    $display("%0d targets, %0d result words, %0d reachable, 6 link settings",
             n_targets, n_results, n_reached);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
